// File: hdl/urgent_front_packet_queue_macros.svh
// Assertion macros for the urgent front packet queue.
// Clock clk and active-low reset rst_n are taken from the using module.
`ifndef URGENT_FRONT_PACKET_QUEUE_MACROS_SVH
`define URGENT_FRONT_PACKET_QUEUE_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define UFPQ_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define UFPQ_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define UFPQ_ASSERT_IMP(lbl, ante, cons, msg)
`define UFPQ_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

// File: hdl/ufpq_pkg.sv
`default_nettype none

package ufpq_pkg;

    // default number of queue entries
    localparam int QUEUE_DEPTH_DEF = 16;

    // packet word width
    localparam int WORD_W = 16;

    // request codes
    localparam logic [1:0] REQ_NORMAL = 2'd0;
    localparam logic [1:0] REQ_URGENT = 2'd1;
    localparam logic [1:0] REQ_SEND   = 2'd2;

    // drop codes
    localparam logic [1:0] DROP_NONE    = 2'd0;
    localparam logic [1:0] DROP_NORMAL  = 2'd1;
    localparam logic [1:0] DROP_EVICTED = 2'd2;

endpackage

`default_nettype wire

// File: hdl/urgent_front_packet_queue.sv
// Outgoing packet queue with an urgent front door. Normal requests append a
// 16-bit word at the tail (discarded when full), urgent requests put the word
// at the head (evicting the old head when full), send requests pop the head.
// Every request yields exactly one result carrying the popped word, the fill
// count after the request and a drop code. Throughput is one request per
// clock while results are taken; a request passes the input register and then
// the result register before its result becomes valid. The entries live in a
// circular buffer memory with one write and one registered read port; the
// read port always tracks the current head entry so a send need not wait for
// a read. Entries are never cleared, so no clearing pass follows reset.
`default_nettype none
`include "urgent_front_packet_queue_macros.svh"

module urgent_front_packet_queue
    import ufpq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int CW          = $clog2(QUEUE_DEPTH + 1)
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,

    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [1:0]        req_type,
    input  wire logic [WORD_W-1:0] packet_word,

    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic                   send_valid,
    output logic [WORD_W-1:0]      sent_word,
    output logic [CW-1:0]          fill_count,
    output logic [1:0]             drop_kind
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam logic [CW-1:0] DEPTH_C    = CW'(QUEUE_DEPTH);
    localparam logic [CW:0]   DEPTH_W    = (CW+1)'(QUEUE_DEPTH);
    localparam logic [PW-1:0] LAST_POS   = PW'(QUEUE_DEPTH - 1);

    // input stage
    logic              in_valid_reg;
    logic [1:0]        req_reg;
    logic [WORD_W-1:0] word_reg;

    // queue state
    logic [PW-1:0]     head_reg,  head_next;
    logic [CW-1:0]     count_reg, count_next;

    // circular buffer and its head read register
    logic [WORD_W-1:0] mem [QUEUE_DEPTH];
    logic [WORD_W-1:0] head_word_reg;

    // result stage
    logic              out_valid_reg;
    logic              send_valid_reg;
    logic [WORD_W-1:0] sent_word_reg;
    logic [CW-1:0]     fill_count_reg;
    logic [1:0]        drop_kind_reg;

    // processing signals
    logic              adv;
    logic              full;
    logic              wr_en;
    logic [PW-1:0]     wr_addr;
    logic [CW:0]       tail_sum;
    logic [CW:0]       tail_wrap;
    logic [PW-1:0]     tail_pos;
    logic [PW-1:0]     head_dec;
    logic [PW-1:0]     head_inc;
    logic              res_valid;
    logic [WORD_W-1:0] res_word;
    logic [1:0]        res_drop;

    // handshake: item in the input stage moves when the result slot frees
    assign adv      = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || adv;

    // pointer arithmetic
    assign full      = (count_reg == DEPTH_C);
    assign tail_sum  = {{(CW + 1 - PW){1'b0}}, head_reg} + {1'b0, count_reg};
    assign tail_wrap = (tail_sum >= DEPTH_W) ? (tail_sum - DEPTH_W) : tail_sum;
    assign tail_pos  = tail_wrap[PW-1:0];
    assign head_dec  = (head_reg == '0) ? LAST_POS : (head_reg - PW'(1));
    assign head_inc  = (head_reg == LAST_POS) ? '0 : (head_reg + PW'(1));

    // request decode and next state
    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        wr_en      = 1'b0;
        wr_addr    = head_reg;
        res_valid  = 1'b0;
        res_word   = '0;
        res_drop   = DROP_NONE;
        if (adv)
        begin
            case (req_reg)
                REQ_NORMAL:
                begin
                    if (full)
                    begin
                        res_drop = DROP_NORMAL;
                    end
                    else
                    begin
                        wr_en      = 1'b1;
                        wr_addr    = tail_pos;
                        count_next = count_reg + CW'(1);
                    end
                end
                REQ_URGENT:
                begin
                    wr_en = 1'b1;
                    if (full)
                    begin
                        wr_addr  = head_reg;
                        res_drop = DROP_EVICTED;
                    end
                    else
                    begin
                        head_next  = head_dec;
                        wr_addr    = head_dec;
                        count_next = count_reg + CW'(1);
                    end
                end
                REQ_SEND:
                begin
                    if (count_reg != '0)
                    begin
                        res_valid  = 1'b1;
                        res_word   = head_word_reg;
                        head_next  = head_inc;
                        count_next = count_reg - CW'(1);
                    end
                end
                default:
                begin
                    res_drop = DROP_NONE;
                end
            endcase
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            head_reg      <= '0;
            count_reg     <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    // input payload
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            req_reg  <= req_type;
            word_reg <= packet_word;
        end
    end

    // buffer write; head read follows the next head with write bypass
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= word_reg;
        end
        if (wr_en && (wr_addr == head_next))
        begin
            head_word_reg <= word_reg;
        end
        else
        begin
            head_word_reg <= mem[head_next];
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            send_valid_reg <= res_valid;
            sent_word_reg  <= res_word;
            fill_count_reg <= count_next;
            drop_kind_reg  <= res_drop;
        end
    end

    assign out_valid  = out_valid_reg;
    assign send_valid = send_valid_reg;
    assign sent_word  = sent_word_reg;
    assign fill_count = fill_count_reg;
    assign drop_kind  = drop_kind_reg;

    // checks
    `UFPQ_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= DEPTH_C, "entry count above depth")
    `UFPQ_ASSERT_IMP(a_head_bound, 1'b1, head_reg <= LAST_POS, "head pointer out of range")
    `UFPQ_ASSERT_IMP(a_evict_full, out_valid_reg && (drop_kind_reg == DROP_EVICTED),
        fill_count_reg == DEPTH_C, "eviction reported on a queue that is not full")
    `UFPQ_ASSERT_IMP(a_word_zero, out_valid_reg && !send_valid_reg,
        sent_word_reg == '0, "sent word nonzero without a send")
    `UFPQ_ASSERT_NXT(a_send_dec, adv && (req_reg == REQ_SEND) && (count_reg != '0),
        count_reg == ($past(count_reg) - CW'(1)), "send did not decrement the count")

endmodule

`default_nettype wire

// File: tb/urgent_front_packet_queue_tb.sv
`default_nettype none

module urgent_front_packet_queue_tb
    import ufpq_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH       = QUEUE_DEPTH_DEF;
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int RAND_ITEMS  = 1750;
    localparam int STUCK_LIMIT = 500;
    localparam int MAX_PRINTS  = 50;

    // unused request code, the block treats it as a no-op
    localparam logic [1:0] REQ_NOOP = 2'd3;

    typedef struct {
        logic [1:0]        req;
        logic [WORD_W-1:0] word;
        int                gap;
        bit                drain;
    } request_t;

    typedef struct packed {
        logic              send_valid;
        logic [WORD_W-1:0] sent_word;
        logic [CNT_W-1:0]  fill_count;
        logic [1:0]        drop_kind;
    } result_t;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic [1:0]        req_type;
    logic [WORD_W-1:0] packet_word;
    logic              out_valid;
    logic              out_ready;
    logic              send_valid;
    logic [WORD_W-1:0] sent_word;
    logic [CNT_W-1:0]  fill_count;
    logic [1:0]        drop_kind;

    request_t outgoing_reqs[$];
    result_t  predicted_results[$];

    // shadow copy of the circular buffer
    logic [WORD_W-1:0] slot_mem [DEPTH];
    logic [3:0]        head_ptr   = '0;
    logic [CNT_W-1:0]  held_count = '0;

    // handshake seen at the last rising edge
    logic in_fire  = 1'b0;
    logic out_fire = 1'b0;

    int  mismatches   = 0;
    int  gap_count    = 0;
    int  ready_hold   = 0;
    int  stuck_cycles = 0;
    bit  sink_calm    = 1'b0;

    urgent_front_packet_queue DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .req_type    (req_type),
        .packet_word (packet_word),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .send_valid  (send_valid),
        .sent_word   (sent_word),
        .fill_count  (fill_count),
        .drop_kind   (drop_kind)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // apply one request to the shadow queue and return its result
    function automatic result_t predict_queue_op(logic [1:0] req, logic [WORD_W-1:0] word);
        result_t    r;
        logic [3:0] tail;
        r = '0;
        r.drop_kind = DROP_NONE;
        case (req)
            REQ_NORMAL:
            begin
                if (held_count == DEPTH)
                    r.drop_kind = DROP_NORMAL;
                else
                begin
                    tail = head_ptr + held_count[3:0];
                    slot_mem[tail] = word;
                    held_count = held_count + 1'b1;
                end
            end
            REQ_URGENT:
            begin
                // full: old head is overwritten in place
                if (held_count == DEPTH)
                begin
                    slot_mem[head_ptr] = word;
                    r.drop_kind = DROP_EVICTED;
                end
                else
                begin
                    head_ptr = head_ptr - 1'b1;
                    slot_mem[head_ptr] = word;
                    held_count = held_count + 1'b1;
                end
            end
            REQ_SEND:
            begin
                if (held_count != 0)
                begin
                    r.send_valid = 1'b1;
                    r.sent_word  = slot_mem[head_ptr];
                    head_ptr     = head_ptr + 1'b1;
                    held_count   = held_count - 1'b1;
                end
            end
            default: ;
        endcase
        r.fill_count = held_count;
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        if (mismatches < MAX_PRINTS)
            $display("ERROR %0t: %s got 0x%0h expected 0x%0h", $time, what, got, want);
        mismatches++;
    endtask

    task automatic add_request(logic [1:0] req, logic [WORD_W-1:0] word, int gap, bit drain);
        request_t it;
        it.req   = req;
        it.word  = word;
        it.gap   = gap;
        it.drain = drain;
        outgoing_reqs.push_back(it);
    endtask

    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(0, 9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // mix of request kinds: 0 fill, 1 drain, 2 balanced, 3 urgent heavy
    function automatic logic [1:0] pick_req(int mix);
        int roll;
        int nrm;
        int urg;
        int snd;
        roll = $urandom_range(0, 99);
        case (mix)
            0:       begin nrm = 50; urg = 25; snd = 20; end
            1:       begin nrm = 15; urg = 10; snd = 70; end
            2:       begin nrm = 30; urg = 25; snd = 40; end
            default: begin nrm = 20; urg = 50; snd = 25; end
        endcase
        if (roll < nrm)
            return REQ_NORMAL;
        if (roll < nrm + urg)
            return REQ_URGENT;
        if (roll < nrm + urg + snd)
            return REQ_SEND;
        return REQ_NOOP;
    endfunction

    function automatic int draw_stall();
        if ($urandom_range(0, 59) == 0)
            sink_calm = !sink_calm;
        return sink_calm ? 0 : $urandom_range(0, 8);
    endfunction

    // source: present queued requests at the falling edge
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_fire))
        begin
            if (outgoing_reqs.size() != 0 && gap_count >= outgoing_reqs[0].gap
                && !(outgoing_reqs[0].drain && predicted_results.size() != 0))
            begin
                req_type    <= outgoing_reqs[0].req;
                packet_word <= outgoing_reqs[0].word;
                in_valid    <= 1'b1;
                void'(outgoing_reqs.pop_front());
                gap_count = 0;
            end
            else
            begin
                in_valid <= 1'b0;
                if (outgoing_reqs.size() != 0 && gap_count < outgoing_reqs[0].gap)
                    gap_count++;
            end
        end
    end

    // sink: random back-pressure on results
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (out_fire)
                ready_hold = draw_stall();
            else if (ready_hold > 0)
                ready_hold--;
            out_ready <= (ready_hold == 0);
        end
    end

    // monitor: predict on input transfer, check on output transfer
    always @(posedge clk)
    begin
        result_t want;
        in_fire  <= rst_n && in_valid && in_ready;
        out_fire <= rst_n && out_valid && out_ready;
        if (rst_n)
        begin
            if (in_valid && in_ready)
                predicted_results.push_back(predict_queue_op(req_type, packet_word));

            if (out_valid && out_ready)
            begin
                if (predicted_results.size() == 0)
                    report_mismatch("result with nothing pending, sent_word", sent_word, 0);
                else
                begin
                    want = predicted_results.pop_front();
                    if (send_valid !== want.send_valid)
                        report_mismatch("send_valid", send_valid, want.send_valid);
                    if (sent_word !== want.sent_word)
                        report_mismatch("sent_word", sent_word, want.sent_word);
                    if (fill_count !== want.fill_count)
                        report_mismatch("fill_count", fill_count, want.fill_count);
                    if (drop_kind !== want.drop_kind)
                        report_mismatch("drop_kind", drop_kind, want.drop_kind);
                end
            end

            // watchdog on cycles without any transfer
            if ((in_valid && in_ready) || (out_valid && out_ready))
                stuck_cycles = 0;
            else
            begin
                stuck_cycles++;
                if (stuck_cycles >= STUCK_LIMIT)
                begin
                    $display("timeout: no transfer for %0d cycles", STUCK_LIMIT);
                    $display("== FAIL ==");
                    $finish;
                end
            end
        end
    end

    initial
    begin
        int  made;
        int  seg_len;
        int  mix;
        bit  calm;
        bit  first_seg;

        rst_n       = 1'b0;
        in_valid    = 1'b0;
        req_type    = REQ_NORMAL;
        packet_word = '0;
        out_ready   = 1'b0;

        // directed: empty cases, fill to full, drops on full, then sends from the head
        add_request(REQ_SEND,   16'h0000, 0, 1'b0);
        add_request(REQ_NOOP,   16'hFFFF, 0, 1'b0);
        add_request(REQ_NORMAL, 16'h0000, 1, 1'b0);
        add_request(REQ_URGENT, 16'hFFFF, 0, 1'b0);
        for (int i = 0; i < 14; i++)
            add_request(REQ_NORMAL, (i % 2) ? 16'hAAAA ^ 16'(i) : 16'h5555 ^ 16'(i << 8),
                        $urandom_range(0, 2), 1'b0);
        add_request(REQ_NORMAL, 16'h1234, 0, 1'b0);
        add_request(REQ_URGENT, 16'h8001, 0, 1'b0);
        add_request(REQ_NOOP,   16'h7FFE, 3, 1'b0);
        for (int i = 0; i < 4; i++)
            add_request(REQ_SEND, 16'hFFFF, i, 1'b0);

        // random: segments biased toward filling, draining or urgent traffic
        made      = 0;
        first_seg = 1'b1;
        while (made < RAND_ITEMS)
        begin
            seg_len = $urandom_range(20, 80);
            mix     = $urandom_range(0, 3);
            calm    = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < seg_len; i++)
                add_request(pick_req(mix), pick_word(), calm ? 0 : $urandom_range(0, 8),
                            i == 0 && (first_seg || $urandom_range(0, 5) == 0));
            made += seg_len;
            first_seg = 1'b0;
        end

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (outgoing_reqs.size() != 0 || in_valid || predicted_results.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);

        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire
